### rtl/core/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types and constants for the greedy disk cover selector: the point
// store word layout, the sequencer states and the pair check result.
// ----------------------------------------------------------------------------
package gdc_pkg;

	localparam int COORD_W    = 10;
	localparam int RADIUS_W   = 21;
	localparam int DIST_W     = 21;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int WORD_W     = 1 + 2 * COORD_W;
	localparam int INDEX_W    = 6;
	localparam int SITES_W    = 7;
	localparam int RESULT_CAP = 64;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 21'd10000;

	// Point store word: covered flag on top, then x, then y.
	typedef struct packed {
		logic               covered;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_word_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_SITE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Result of one pair check leaving the distance pipeline.
	typedef struct packed {
		logic               vld;
		logic               hit;
		logic               busy;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pair_res_t;

endpackage

### rtl/core/gdc_ram.sv
// ----------------------------------------------------------------------------
// gdc_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gdc_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/gdc_disk_pipe.sv
// ----------------------------------------------------------------------------
// gdc_disk_pipe
// Three-stage pair check: absolute differences, squares, then the sum is
// compared against the radius. A point always lies in its own disk.
// ----------------------------------------------------------------------------
module gdc_disk_pipe #(
	parameter int IDX_W = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              iss_vld,
	input  logic [IDX_W-1:0]                  iss_idx,
	input  gdc_pkg::point_word_t              rd_word,
	input  logic [gdc_pkg::COORD_W-1:0]       site_x,
	input  logic [gdc_pkg::COORD_W-1:0]       site_y,
	input  logic [IDX_W-1:0]                  site_idx,
	input  logic [gdc_pkg::RADIUS_W-1:0]      radius,
	output gdc_pkg::pair_res_t                res,
	output logic [IDX_W-1:0]                  res_idx
);

	logic                          vld_s1, vld_s2, vld_s3;
	logic [IDX_W-1:0]              idx_s1, idx_s2, idx_s3;
	logic [gdc_pkg::COORD_W-1:0]   dx_s2, dy_s2, x_s2, y_s2, x_s3, y_s3;
	logic                          unc_s2, self_s2, unc_s3, self_s3;
	logic [gdc_pkg::SQ_W-1:0]      sqx_s3, sqy_s3;
	logic [gdc_pkg::COORD_W-1:0]   dx, dy;
	logic [gdc_pkg::DIST_W-1:0]    dist_sq;

	assign dx = (rd_word.x > site_x) ? rd_word.x - site_x : site_x - rd_word.x;
	assign dy = (rd_word.y > site_y) ? rd_word.y - site_y : site_y - rd_word.y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= iss_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= iss_idx;
		dx_s2   <= dx;
		dy_s2   <= dy;
		x_s2    <= rd_word.x;
		y_s2    <= rd_word.y;
		unc_s2  <= ~rd_word.covered;
		self_s2 <= (idx_s1 == site_idx);
		idx_s2  <= idx_s1;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		unc_s3  <= unc_s2;
		self_s3 <= self_s2;
		idx_s3  <= idx_s2;
	end

	assign dist_sq  = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign res.vld  = vld_s3;
	assign res.hit  = vld_s3 & unc_s3 & (self_s3 | (dist_sq < radius));
	assign res.busy = vld_s1 | vld_s2 | vld_s3;
	assign res.x    = x_s3;
	assign res.y    = y_s3;
	assign res_idx  = idx_s3;

endmodule

### rtl/core/greedy_disk_cover_selector_core.sv
// ----------------------------------------------------------------------------
// greedy_disk_cover_selector_core
// Greedy unit-disk cover: loads a set of points, then picks transmitter
// sites one by one until every point of the set is covered.
// ----------------------------------------------------------------------------
// Usage. Points arrive on the input channel (in_valid/in_ready), one beat
// per point; the beat with last_point set closes the set and starts the
// selection. Points past MAX_POINTS are dropped, but a closing beat still
// starts the selection. Inputs are taken one per cycle while loading.
// Each chosen site leaves on the output channel (out_valid/out_ready) as one
// beat, with last_site set on the final one; at most 64 beats per set.
// Each choice scans every candidate row, each row being a site fetch, one
// store read per point held and a pipeline drain, and then one marking row.
// The single read port of the point store makes the rows run one by one.
// The output is a register: while a site waits to be taken the next choice
// is already computed, and the sequencer pauses only when a second site is
// ready before the first has gone. After the final site the block takes the
// next set's points at once, even if that site is still waiting.
// Reset empties the set and restores the radius to its reset value; the
// point store needs no clearing, as each entry is rewritten as it loads.
// The radius register is written through cfg_wen/cfg_wdata; the user must write it only while idle (not enforced).
// ----------------------------------------------------------------------------
module greedy_disk_cover_selector_core #(
	parameter int MAX_POINTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [gdc_pkg::RADIUS_W-1:0]      cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [gdc_pkg::COORD_W-1:0]       x_coord,
	input  logic [gdc_pkg::COORD_W-1:0]       y_coord,
	input  logic                              last_point,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gdc_pkg::INDEX_W-1:0]       chosen_index,
	output logic [gdc_pkg::SITES_W-1:0]       sites_so_far,
	output logic                              last_site
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	gdc_pkg::state_t state_q, state_d;

	// Set bookkeeping.
	logic [CNT_W-1:0]                 loaded_q, n_q, count_q, best_cnt_q, covered_q;
	logic [IDX_W-1:0]                 last_idx_q, row_q, j_q, best_q;
	logic                             mark_q, emit_last_q;
	logic [gdc_pkg::SITES_W-1:0]      sites_q;
	logic [gdc_pkg::COORD_W-1:0]      site_x_q, site_y_q;
	logic [gdc_pkg::RADIUS_W-1:0]     radius_q;

	// Output register.
	logic                             out_valid_q, out_last_q;
	logic [gdc_pkg::INDEX_W-1:0]      out_index_q;
	logic [gdc_pkg::SITES_W-1:0]      out_sites_q;

	// Store access.
	logic                             ram_we;
	logic [IDX_W-1:0]                 ram_waddr, ram_raddr;
	gdc_pkg::point_word_t             ram_wdata, ram_rdata;
	logic                             iss_vld;
	logic [IDX_W-1:0]                 site_idx, res_idx;
	gdc_pkg::pair_res_t               res;

	logic                             in_fire, store_room, out_free;
	logic [CNT_W-1:0]                 n_next, new_total;

	assign in_fire    = in_valid & in_ready;
	assign store_room = (loaded_q < CNT_W'(MAX_POINTS));
	assign n_next     = loaded_q + CNT_W'(store_room);
	assign out_free   = ~out_valid_q | out_ready;
	assign site_idx   = mark_q ? best_q : row_q;
	assign new_total  = covered_q + count_q;

	gdc_ram #(
		.WIDTH(gdc_pkg::WORD_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	gdc_disk_pipe #(
		.IDX_W(IDX_W)
	) u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.iss_vld (iss_vld),
		.iss_idx (j_q),
		.rd_word (ram_rdata),
		.site_x  (site_x_q),
		.site_y  (site_y_q),
		.site_idx(site_idx),
		.radius  (radius_q),
		.res     (res),
		.res_idx (res_idx)
	);

	// Next state and store port control.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		iss_vld   = 1'b0;
		ram_raddr = j_q;
		ram_we    = 1'b0;
		ram_waddr = res_idx;
		ram_wdata = '{covered: 1'b1, x: res.x, y: res.y};
		case (state_q)
			gdc_pkg::ST_LOAD: begin
				in_ready  = 1'b1;
				ram_we    = in_fire & store_room;
				ram_waddr = loaded_q[IDX_W-1:0];
				ram_wdata = '{covered: 1'b0, x: x_coord, y: y_coord};
				if (in_fire && last_point) begin
					state_d = gdc_pkg::ST_FETCH;
				end
			end
			gdc_pkg::ST_FETCH: begin
				ram_raddr = site_idx;
				state_d   = gdc_pkg::ST_SITE;
			end
			gdc_pkg::ST_SITE: begin
				state_d = gdc_pkg::ST_SCAN;
			end
			gdc_pkg::ST_SCAN: begin
				iss_vld = 1'b1;
				ram_we  = mark_q & res.hit;
				if (j_q == last_idx_q) begin
					state_d = gdc_pkg::ST_DRAIN;
				end
			end
			gdc_pkg::ST_DRAIN: begin
				ram_we = mark_q & res.hit;
				if (!res.busy) begin
					if (mark_q) begin
						state_d = gdc_pkg::ST_EMIT;
					end else begin
						state_d = gdc_pkg::ST_FETCH;
					end
				end
			end
			gdc_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = emit_last_q ? gdc_pkg::ST_LOAD : gdc_pkg::ST_FETCH;
				end
			end
			default: begin
				state_d = gdc_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			n_q         <= '0;
			last_idx_q  <= '0;
			row_q       <= '0;
			j_q         <= '0;
			best_q      <= '0;
			best_cnt_q  <= '0;
			count_q     <= '0;
			covered_q   <= '0;
			mark_q      <= 1'b0;
			emit_last_q <= 1'b0;
			sites_q     <= '0;
			radius_q    <= gdc_pkg::RADIUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				radius_q <= cfg_wdata;
			end
			// A new site refills the output register in the cycle the
			// waiting beat leaves, so valid stays high across the swap.
			if (state_q == gdc_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (res.hit) begin
				count_q <= count_q + CNT_W'(1);
			end
			case (state_q)
				gdc_pkg::ST_LOAD: begin
					if (in_fire) begin
						if (last_point) begin
							n_q        <= n_next;
							last_idx_q <= IDX_W'(n_next - CNT_W'(1));
							loaded_q   <= '0;
							row_q      <= '0;
							mark_q     <= 1'b0;
							best_q     <= '0;
							best_cnt_q <= '0;
							covered_q  <= '0;
							sites_q    <= '0;
						end else begin
							loaded_q <= n_next;
						end
					end
				end
				gdc_pkg::ST_FETCH: begin
					count_q <= '0;
				end
				gdc_pkg::ST_SITE: begin
					j_q <= '0;
				end
				gdc_pkg::ST_SCAN: begin
					j_q <= j_q + IDX_W'(1);
				end
				gdc_pkg::ST_DRAIN: begin
					if (!res.busy) begin
						if (mark_q) begin
							covered_q   <= new_total;
							sites_q     <= sites_q + gdc_pkg::SITES_W'(1);
							emit_last_q <= (new_total == n_q) ||
							               (sites_q + gdc_pkg::SITES_W'(1) ==
							                gdc_pkg::SITES_W'(gdc_pkg::RESULT_CAP));
						end else begin
							// Strictly greater: the lowest index wins a tie.
							if (count_q > best_cnt_q) begin
								best_q     <= row_q;
								best_cnt_q <= count_q;
							end
							if (row_q == last_idx_q) begin
								mark_q <= 1'b1;
							end else begin
								row_q <= row_q + IDX_W'(1);
							end
						end
					end
				end
				gdc_pkg::ST_EMIT: begin
					if (out_free) begin
						row_q       <= '0;
						mark_q      <= 1'b0;
						best_q      <= '0;
						best_cnt_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == gdc_pkg::ST_SITE) begin
			site_x_q <= ram_rdata.x;
			site_y_q <= ram_rdata.y;
		end
		if (state_q == gdc_pkg::ST_EMIT && out_free) begin
			out_index_q <= gdc_pkg::INDEX_W'(best_q);
			out_sites_q <= sites_q;
			out_last_q  <= emit_last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_index = out_index_q;
	assign sites_so_far = out_sites_q;
	assign last_site    = out_last_q;

	// Covered total never runs past the number of points held.
	a_covered_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gdc_pkg::ST_LOAD) |-> (covered_q <= n_q))
		else $error("covered total exceeds the set size");

	// Every chosen site covers at least one new point.
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdc_pkg::ST_DRAIN && mark_q && !res.busy) |-> (count_q != '0))
		else $error("chosen site covers no new point");

	// Marking writes only land on points of the current set.
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != gdc_pkg::ST_LOAD) |-> (mark_q && ram_waddr <= last_idx_q))
		else $error("store write outside the marking pass");

	// A new choice is never dropped onto a waiting beat.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(out_sites_q))
		else $error("output beat overwritten before it was taken");

	// The site count stays within the result cap.
	a_sites_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sites_q <= gdc_pkg::SITES_W'(gdc_pkg::RESULT_CAP))
		else $error("site count beyond result cap");

endmodule

### dv/greedy_disk_cover_selector_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_disk_cover_selector_checker
// Watches both channels and the radius port of the greedy disk cover
// selector. It keeps its own copy of the point set and the radius, plans the
// transmitter sites when a set closes, and compares every site beat in order.
// ----------------------------------------------------------------------------
module greedy_disk_cover_selector_checker #(
	parameter int MAX_POINTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [gdc_pkg::RADIUS_W-1:0] cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [gdc_pkg::COORD_W-1:0]  x_coord,
	input  logic [gdc_pkg::COORD_W-1:0]  y_coord,
	input  logic                         last_point,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [gdc_pkg::INDEX_W-1:0]  chosen_index,
	input  logic [gdc_pkg::SITES_W-1:0]  sites_so_far,
	input  logic                         last_site,
	output int                           error_count,
	output int                           pending
);

	typedef struct packed {
		logic [gdc_pkg::INDEX_W-1:0] index;
		logic [gdc_pkg::SITES_W-1:0] count;
		logic                        last;
	} site_t;

	site_t                        sites_due[$];
	logic [gdc_pkg::COORD_W-1:0]  set_x [MAX_POINTS];
	logic [gdc_pkg::COORD_W-1:0]  set_y [MAX_POINTS];
	logic [gdc_pkg::RADIUS_W-1:0] radius;
	int                           held;
	int                           mismatches = 0;

	// A point always covers itself; otherwise the squared distance must be
	// strictly below the radius.
	function automatic bit covers(int a, int b);
		logic [gdc_pkg::DIST_W-1:0] dx, dy, d2;
		if (a == b)
			return 1'b1;
		dx = (set_x[a] > set_x[b]) ? set_x[a] - set_x[b] : set_x[b] - set_x[a];
		dy = (set_y[a] > set_y[b]) ? set_y[a] - set_y[b] : set_y[b] - set_y[a];
		d2 = dx * dx + dy * dy;
		return d2 < radius;
	endfunction

	// Greedy choice over the points held, lowest index winning ties.
	function automatic void plan_sites();
		logic [MAX_POINTS-1:0] covered;
		int done, sites, best, best_hits, hits;
		site_t s;
		covered = '0;
		done = 0;
		sites = 0;
		while (done < held) begin
			best = 0;
			best_hits = 0;
			for (int i = 0; i < held; i++) begin
				hits = 0;
				for (int j = 0; j < held; j++)
					if (!covered[j] && covers(i, j))
						hits++;
				if (hits > best_hits) begin
					best_hits = hits;
					best = i;
				end
			end
			for (int j = 0; j < held; j++) begin
				if (!covered[j] && covers(best, j)) begin
					covered[j] = 1'b1;
					done++;
				end
			end
			sites++;
			if (sites <= gdc_pkg::RESULT_CAP) begin
				s.index = gdc_pkg::INDEX_W'(best);
				s.count = gdc_pkg::SITES_W'(sites);
				s.last = 1'b0;
				sites_due.push_back(s);
			end
		end
		s = sites_due.pop_back();
		s.last = 1'b1;
		sites_due.push_back(s);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		site_t want;
		if (!arst_n) begin
			radius = gdc_pkg::RADIUS_RESET;
			held = 0;
			sites_due.delete();
			pending <= 0;
			error_count <= mismatches;
		end else begin
			if (cfg_wen)
				radius = cfg_wdata;
			if (in_valid && in_ready) begin
				if (held < MAX_POINTS) begin
					set_x[held] = x_coord;
					set_y[held] = y_coord;
					held++;
				end
				if (last_point) begin
					plan_sites();
					held = 0;
				end
			end
			if (out_valid && out_ready) begin
				if (sites_due.size() == 0) begin
					mismatches++;
					$display("%0t: site beat with none expected: index %0d, count %0d, last %0d",
						$time, chosen_index, sites_so_far, last_site);
				end else begin
					want = sites_due.pop_front();
					if (chosen_index !== want.index) begin
						mismatches++;
						$display("%0t: chosen_index expected %0d, actual %0d",
							$time, want.index, chosen_index);
					end
					if (sites_so_far !== want.count) begin
						mismatches++;
						$display("%0t: sites_so_far expected %0d, actual %0d",
							$time, want.count, sites_so_far);
					end
					if (last_site !== want.last) begin
						mismatches++;
						$display("%0t: last_site expected %0d, actual %0d",
							$time, want.last, last_site);
					end
				end
			end
			pending <= sites_due.size();
			error_count <= mismatches;
		end
	end

endmodule

### dv/greedy_disk_cover_selector_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_disk_cover_selector_core_test
// Drives point sets into the greedy disk cover selector under several radius
// settings, with random idling on both channels, and reports the verdict
// from the failure count of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module greedy_disk_cover_selector_core_test;

	localparam int MAX_POINTS   = 64;
	// The receiver's long hold-off, long enough for the block to fill its
	// output register and the next choice, and so stall its input.
	localparam int LONG_HOLD    = 3000;
	localparam int DRAIN_CYCLES = 5000;
	localparam int CFG_SETTLE   = 8;
	localparam int RANDOM_ITEMS = 55;
	localparam int CALM_AFTER   = 40;

	localparam logic [gdc_pkg::RADIUS_W-1:0] RADIUS_MAX = '1;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wen = 1'b0;
	logic [gdc_pkg::RADIUS_W-1:0] cfg_wdata = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [gdc_pkg::COORD_W-1:0]  x_coord = '0;
	logic [gdc_pkg::COORD_W-1:0]  y_coord = '0;
	logic                         last_point = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [gdc_pkg::INDEX_W-1:0]  chosen_index;
	logic [gdc_pkg::SITES_W-1:0]  sites_so_far;
	logic                         last_site;

	int error_count;
	int pending;

	// Set once the run enters its final stretch, where neither side idles.
	bit calm = 1'b0;
	// Asks the receiver for its single long hold-off.
	bit hold_off_req = 1'b0;
	int random_items = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	greedy_disk_cover_selector_core #(
		.MAX_POINTS(MAX_POINTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chosen_index(chosen_index),
		.sites_so_far(sites_so_far),
		.last_site(last_site)
	);

	greedy_disk_cover_selector_checker #(
		.MAX_POINTS(MAX_POINTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chosen_index(chosen_index),
		.sites_so_far(sites_so_far),
		.last_site(last_site),
		.error_count(error_count),
		.pending(pending)
	);

	// Offers one point beat, possibly after a short idle burst, and returns at
	// the edge that accepted it. Valid stays high on return, so the next
	// point can follow straight on; anything else that lets time pass must
	// lower valid first.
	task automatic send_point(input logic [gdc_pkg::COORD_W-1:0] x,
			input logic [gdc_pkg::COORD_W-1:0] y, input logic last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		last_point <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering and waits until every planned site has been taken.
	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// The radius is only written while the block sits idle between sets.
	task automatic write_radius(input logic [gdc_pkg::RADIUS_W-1:0] value);
		quiesce();
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_wdata <= value;
		cfg_wen <= 1'b1;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// One set of n points, either spread over the whole plane or packed into
	// a small patch so that disks overlap and the greedy choice has work.
	task automatic send_set(input int n, input bit cluster);
		logic [gdc_pkg::COORD_W-1:0] bx, by;
		bx = gdc_pkg::COORD_W'($urandom_range(0, 896));
		by = gdc_pkg::COORD_W'($urandom_range(0, 896));
		for (int k = 0; k < n; k++) begin
			if (cluster)
				send_point(bx + gdc_pkg::COORD_W'($urandom_range(0, 127)),
					by + gdc_pkg::COORD_W'($urandom_range(0, 127)), k == n - 1);
			else
				send_point(gdc_pkg::COORD_W'($urandom_range(0, 1023)),
					gdc_pkg::COORD_W'($urandom_range(0, 1023)), k == n - 1);
		end
	endtask

	// Receiver: random idle bursts on out_ready until the final stretch, and
	// once, on request, a long hold-off counted here while the sender keeps
	// offering the next set.
	initial begin : receiver
		bit held_off;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !held_off && out_valid) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [gdc_pkg::RADIUS_W-1:0] r;
		int n;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset radius. A lone point is its own site.
		send_point(10'd0, 10'd0, 1'b1);
		// Exactly on the radius is outside the disk, so two sites.
		send_point(10'd0, 10'd0, 1'b0);
		send_point(10'd100, 10'd0, 1'b1);
		// Just inside: the first two tie and the lower index must win.
		send_point(10'd0, 10'd0, 1'b0);
		send_point(10'd99, 10'd0, 1'b0);
		send_point(10'd1023, 10'd1023, 1'b1);
		// Corners of the plane and the centre, all far apart.
		send_point(10'd1023, 10'd1023, 1'b0);
		send_point(10'd1023, 10'd0, 1'b0);
		send_point(10'd0, 10'd1023, 1'b0);
		send_point(10'd0, 10'd0, 1'b0);
		send_point(10'd512, 10'd512, 1'b1);
		// Coincident points fall under one disk.
		send_point(10'd300, 10'd300, 1'b0);
		send_point(10'd300, 10'd300, 1'b0);
		send_point(10'd300, 10'd300, 1'b1);

		// Zero radius: every point, even a coincident one, is chosen alone.
		// The receiver holds off on the first site here, so the block fills
		// up while the second set is already being offered behind it.
		write_radius('0);
		hold_off_req = 1'b1;
		send_point(10'd10, 10'd10, 1'b0);
		send_point(10'd20, 10'd20, 1'b0);
		send_point(10'd30, 10'd30, 1'b0);
		send_point(10'd40, 10'd40, 1'b1);
		send_point(10'd700, 10'd200, 1'b0);
		send_point(10'd700, 10'd200, 1'b0);
		send_point(10'd700, 10'd200, 1'b1);

		// Largest radius covers the whole plane. The set overruns the store:
		// the surplus points are dropped and the closing beat still starts
		// the selection over the points held.
		write_radius(RADIUS_MAX);
		for (int k = 0; k < MAX_POINTS + 2; k++)
			send_point(gdc_pkg::COORD_W'($urandom_range(0, 1023)),
				gdc_pkg::COORD_W'($urandom_range(0, 1023)), k == MAX_POINTS + 1);

		// Random part: a fresh radius for each phase, then a few sets of
		// mostly small sizes, now and then waiting for all their sites.
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: r = gdc_pkg::RADIUS_W'($urandom_range(0, 2097151));
				1: r = gdc_pkg::RADIUS_W'($urandom_range(0, 4000));
				default: r = gdc_pkg::RADIUS_W'($urandom_range(4000, 60000));
			endcase
			write_radius(r);
			repeat ($urandom_range(2, 5)) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
				send_set(n, 1'($urandom_range(0, 1)));
				random_items += n;
				if (random_items >= CALM_AFTER)
					calm = 1'b1;
				if ($urandom_range(0, 3) == 0)
					quiesce();
			end
		end

		// Let every site arrive, then watch a while longer for strays.
		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Guard against a hang: far beyond the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
